FILE: design/ssre_pkg.sv
`timescale 1ns / 1ps

package ssre_pkg;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_NUMBER_MODE   = 3'd0,
        REG_BLINK_ENABLE  = 3'd1,
        REG_FIXED_DOT     = 3'd2,
        REG_RUNNING_DOT   = 3'd3,
        REG_TEXT_SEGMENTS = 3'd4
    } reg_index_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int VALUE_W     = 11;
    localparam int GRID_W      = 7;
    localparam int SEG_W       = 8;

    // Digit address commands.
    localparam logic [GRID_W-1:0] GRID_DIGIT0 = 7'h68;
    localparam logic [GRID_W-1:0] GRID_DIGIT1 = 7'h6A;
    localparam logic [GRID_W-1:0] GRID_DIGIT2 = 7'h6C;

    localparam logic [SEG_W-1:0] MINUS_SEG = 8'h40;
    localparam logic [SEG_W-1:0] DOT_SEG   = 8'h80;

    // Work item passed from the front to the back through the queue.
    typedef struct packed {
        logic        number_mode;
        logic        negative;
        logic [10:0] mag;
        logic [6:0]  quot10;
        logic [3:0]  quot100;
        logic        blank;
        logic [2:0]  dot_mask;
    } work_t;

    // Handshake between the queue and the back end.
    typedef struct packed {
        logic empty;
        logic pop;
    } qctl_t;

    // Seven-segment font for decimal digits.
    function automatic logic [SEG_W-1:0] digit_font(input logic [3:0] digit);
        logic [SEG_W-1:0] seg;
        case (digit)
            4'd0: seg = 8'h3F;
            4'd1: seg = 8'h06;
            4'd2: seg = 8'h5B;
            4'd3: seg = 8'h4F;
            4'd4: seg = 8'h66;
            4'd5: seg = 8'h6D;
            4'd6: seg = 8'h7D;
            4'd7: seg = 8'h07;
            4'd8: seg = 8'h7F;
            4'd9: seg = 8'h6F;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

FILE: design/ssre_front.sv
`timescale 1ns / 1ps

module ssre_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [ssre_pkg::VALUE_W-1:0] s_value,
    input  logic                         number_mode,
    input  logic                         blink_enable,
    input  logic                         fixed_dot_enable,
    input  logic                         running_dot_enable,
    input  logic                         q_full,
    output logic                         push,
    output ssre_pkg::work_t              push_work
);
    import ssre_pkg::*;

    logic [2:0]  tick_reg, tick_next;
    logic        phase_reg, phase_next;
    logic [1:0]  dot_reg, dot_next;
    logic        accept;
    logic        negative;
    logic [10:0] mag;
    logic [18:0] prod10;
    logic [16:0] prod100;
    logic [2:0]  dot_mask;

    assign s_ready = !q_full;
    assign accept  = s_valid && !q_full;
    assign push    = accept;

    // Magnitude of the value; -1024 comes out as 1024 in 11 unsigned bits.
    assign negative = s_value[VALUE_W-1];
    assign mag      = negative ? (~s_value + 11'd1) : s_value;

    // Quotients by 10 and 100 through reciprocal multiplies, exact for mag <= 1024.
    assign prod10  = 19'(mag) * 19'd205;
    assign prod100 = 17'(mag) * 17'd41;

    // Tick counter, blink phase and running dot advance for the accepted beat.
    always_comb begin
        tick_next  = (tick_reg >= 3'd5) ? 3'd0 : tick_reg + 3'd1;
        phase_next = phase_reg;
        dot_next   = dot_reg;
        dot_mask   = 3'b000;
        if (tick_next == 3'd0 || tick_next == 3'd3) begin
            phase_next = !phase_reg;
        end
        if (fixed_dot_enable) begin
            dot_mask = 3'b001;
        end else if (running_dot_enable) begin
            if (!tick_next[0]) begin
                dot_next = (dot_reg >= 2'd2) ? 2'd0 : dot_reg + 2'd1;
            end
            dot_mask = 3'(3'b001 << dot_next);
        end
    end

    // Fill in the work item.
    always_comb begin
        push_work.number_mode = number_mode;
        push_work.negative    = negative;
        push_work.mag         = mag;
        push_work.quot10      = prod10[17:11];
        push_work.quot100     = prod100[15:12];
        push_work.blank       = blink_enable && !phase_reg;
        push_work.dot_mask    = dot_mask;
    end

    // Display state advances once per accepted beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg  <= 3'd0;
            phase_reg <= 1'b0;
            dot_reg   <= 2'd0;
        end else if (accept) begin
            tick_reg  <= tick_next;
            phase_reg <= phase_next;
            dot_reg   <= dot_next;
        end
    end

endmodule

FILE: design/ssre_queue.sv
`timescale 1ns / 1ps

module ssre_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  ssre_pkg::work_t push_work,
    output logic            full,
    input  ssre_pkg::qctl_t ctl_in,
    output logic            empty,
    output ssre_pkg::work_t head
);
    import ssre_pkg::*;

    work_t      slots [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    assign full   = (count_reg == 2'd2);
    assign empty  = (count_reg == 2'd0);
    assign head   = slots[rd_ptr_reg];
    assign do_pop = ctl_in.pop && !ctl_in.empty;

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_work;
        end
    end

endmodule

FILE: design/ssre_back.sv
`timescale 1ns / 1ps

module ssre_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             empty,
    input  ssre_pkg::work_t                  head,
    output ssre_pkg::qctl_t                  ctl_out,
    input  logic [ssre_pkg::CFG_DATA_W-1:0]  text_segments,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [ssre_pkg::GRID_W-1:0]      m_grid_command,
    output logic [ssre_pkg::SEG_W-1:0]       m_segments,
    output logic                             m_last
);
    import ssre_pkg::*;

    logic              valid_reg, valid_next;
    logic [1:0]        idx_reg, idx_next;
    logic [GRID_W-1:0] grid_reg, grid_next;
    logic [SEG_W-1:0]  seg_reg, seg_next;
    logic              last_reg, last_next;
    logic              advance;
    logic [10:0]       rem10;
    logic [6:0]        rem100;
    logic [3:0]        d0, d1, d2;
    logic [SEG_W-1:0]  base_seg;

    assign advance = !valid_reg || m_ready;

    // Remainders recover the decimal digits from the quotients.
    assign rem10  = head.mag - 11'(head.quot10) * 11'd10;
    assign rem100 = head.quot10 - 7'(head.quot100) * 7'd10;
    assign d0     = rem10[3:0];
    assign d1     = rem100[3:0];
    assign d2     = (head.quot100 >= 4'd10) ? head.quot100 - 4'd10 : head.quot100;

    // Segment byte for the current digit before the decimal point.
    always_comb begin
        base_seg  = '0;
        grid_next = GRID_DIGIT0;
        case (idx_reg)
            2'd0: begin
                grid_next = GRID_DIGIT0;
                base_seg  = head.number_mode ? digit_font(d0) : text_segments[7:0];
            end
            2'd1: begin
                grid_next = GRID_DIGIT1;
                base_seg  = head.number_mode ? digit_font(d1) : text_segments[15:8];
            end
            2'd2: begin
                grid_next = GRID_DIGIT2;
                if (!head.number_mode) begin
                    base_seg = text_segments[23:16];
                end else if (head.negative) begin
                    base_seg = MINUS_SEG;
                end else begin
                    base_seg = digit_font(d2);
                end
            end
            default: begin
                grid_next = GRID_DIGIT0;
                base_seg  = '0;
            end
        endcase
        if (head.blank) begin
            base_seg = '0;
        end
    end

    // Next frame: blanking first, then the decimal point.
    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        seg_next   = base_seg | (head.dot_mask[idx_reg] ? DOT_SEG : '0);
        last_next  = (idx_reg == 2'd2);
        if (advance) begin
            valid_next = !empty;
            if (!empty) begin
                idx_next = (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    assign ctl_out.empty = empty;
    assign ctl_out.pop   = advance && !empty && (idx_reg == 2'd2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Output register holds the frame until it is taken.
    always_ff @(posedge aclk) begin
        if (advance && !empty) begin
            grid_reg <= grid_next;
            seg_reg  <= seg_next;
            last_reg <= last_next;
        end
    end

    assign m_valid        = valid_reg;
    assign m_grid_command = grid_reg;
    assign m_segments     = seg_reg;
    assign m_last         = last_reg;

endmodule

FILE: design/seven_segment_refresh_engine_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_value (11-bit signed)
// m_        out        m_valid/m_ready    m_grid_command, m_segments, m_last
// cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// Each accepted beat yields three frames, one per clock while m_ready is high, so the
// back end, which emits one digit per cycle, sets the sustained input rate.
// Each input beat is written into a queue slot and from there into the output register;
// a two-entry queue separates the sides.
// Reset is synchronous, active low, and clears the display state and queue.
// A stall on m_ready holds the output register; the front keeps accepting until full.

module seven_segment_refresh_engine_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [ssre_pkg::VALUE_W-1:0] s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ssre_pkg::GRID_W-1:0]         m_grid_command,
    output logic [ssre_pkg::SEG_W-1:0]          m_segments,
    output logic                                m_last,
    input  logic                                cfg_we,
    input  logic [ssre_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ssre_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import ssre_pkg::*;

    logic                  number_mode_reg;
    logic                  blink_enable_reg;
    logic                  fixed_dot_reg;
    logic                  running_dot_reg;
    logic [CFG_DATA_W-1:0] text_reg;
    logic                  q_full;
    logic                  q_empty;
    logic                  push;
    work_t                 push_work;
    work_t                 head;
    qctl_t                 qctl;

    // Configuration registers; unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            number_mode_reg  <= 1'b1;
            blink_enable_reg <= 1'b0;
            fixed_dot_reg    <= 1'b0;
            running_dot_reg  <= 1'b0;
            text_reg         <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_NUMBER_MODE:   number_mode_reg  <= cfg_wdata[0];
                REG_BLINK_ENABLE:  blink_enable_reg <= cfg_wdata[0];
                REG_FIXED_DOT:     fixed_dot_reg    <= cfg_wdata[0];
                REG_RUNNING_DOT:   running_dot_reg  <= cfg_wdata[0];
                REG_TEXT_SEGMENTS: text_reg         <= cfg_wdata;
                default: ;
            endcase
        end
    end

    ssre_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_value            (s_value),
        .number_mode        (number_mode_reg),
        .blink_enable       (blink_enable_reg),
        .fixed_dot_enable   (fixed_dot_reg),
        .running_dot_enable (running_dot_reg),
        .q_full             (q_full),
        .push               (push),
        .push_work          (push_work)
    );

    ssre_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_work (push_work),
        .full      (q_full),
        .ctl_in    (qctl),
        .empty     (q_empty),
        .head      (head)
    );

    ssre_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .empty          (q_empty),
        .head           (head),
        .ctl_out        (qctl),
        .text_segments  (text_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_grid_command (m_grid_command),
        .m_segments     (m_segments),
        .m_last         (m_last)
    );

    // The last frame of a refresh always addresses the top digit.
    a_last_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_grid_command == GRID_DIGIT2)
        else $error("last frame not on top digit");

    // Earlier frames never address the top digit.
    a_not_last_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> m_grid_command != GRID_DIGIT2)
        else $error("top digit frame without last");

    // A pop only happens with a frame being issued from a non-empty queue.
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        qctl.pop |=> m_valid && m_last)
        else $error("queue popped without issuing the last frame");

endmodule

FILE: verif/ssre_frame_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the refresh engine, predicts the three digit frames of
// every accepted input beat and compares each output beat against the oldest one.
module ssre_frame_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic signed [ssre_pkg::VALUE_W-1:0] s_value,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [ssre_pkg::GRID_W-1:0]         m_grid_command,
    input  logic [ssre_pkg::SEG_W-1:0]          m_segments,
    input  logic                                m_last,
    input  logic                                cfg_we,
    input  logic [ssre_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ssre_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output int                                  mismatches,
    output int                                  frames_pending
);

    import ssre_pkg::*;

    typedef struct packed {
        logic [GRID_W-1:0] grid;
        logic [SEG_W-1:0]  seg;
        logic              last;
    } frame_t;

    // Segment patterns for the digits 0 to 9, digit 0 in the lowest byte.
    localparam logic [10*SEG_W-1:0] DIGIT_PATTERNS = {
        8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
    };

    localparam logic [2:0][GRID_W-1:0] DIGIT_GRIDS = {GRID_DIGIT2, GRID_DIGIT1, GRID_DIGIT0};

    // Mirror of the configuration registers.
    logic                  show_number;
    logic                  blink_on;
    logic                  fixed_dot;
    logic                  running_dot;
    logic [CFG_DATA_W-1:0] text_bytes;

    // Mirror of the display state.
    logic [2:0] tick_count;
    logic       blink_phase;
    logic [1:0] dot_position;

    frame_t frames_due [$];

    // Advance the display state by one refresh tick and queue its three frames.
    task automatic refresh_digits(input logic [VALUE_W-1:0] raw);
        logic                  negative;
        int                    mag;
        logic [2:0][SEG_W-1:0] seg;
        frame_t                fr;
        negative = raw[VALUE_W-1];
        mag = negative ? (1 << VALUE_W) - int'(raw) : int'(raw);
        seg = '0;

        tick_count = (tick_count >= 3'd5) ? 3'd0 : tick_count + 3'd1;

        // Blanking looks at the phase before it toggles.
        if (!(blink_on && !blink_phase)) begin
            if (show_number) begin
                seg[0] = DIGIT_PATTERNS[(mag % 10) * SEG_W +: SEG_W];
                seg[1] = DIGIT_PATTERNS[((mag / 10) % 10) * SEG_W +: SEG_W];
                seg[2] = negative ? MINUS_SEG
                                  : DIGIT_PATTERNS[((mag / 100) % 10) * SEG_W +: SEG_W];
            end else begin
                seg[0] = text_bytes[7:0];
                seg[1] = text_bytes[15:8];
                seg[2] = text_bytes[23:16];
            end
        end

        if (tick_count % 3 == 0) begin
            blink_phase = ~blink_phase;
        end

        // Decimal points go on top of blanking; the fixed dot wins over the running one.
        if (fixed_dot) begin
            seg[0] = seg[0] | DOT_SEG;
        end else if (running_dot) begin
            if (!tick_count[0]) begin
                dot_position = (dot_position >= 2'd2) ? 2'd0 : dot_position + 2'd1;
            end
            seg[dot_position] = seg[dot_position] | DOT_SEG;
        end

        for (int k = 0; k < 3; k++) begin
            fr.grid = DIGIT_GRIDS[k];
            fr.seg  = seg[k];
            fr.last = (k == 2);
            frames_due.push_back(fr);
        end
    endtask

    always @(posedge aclk) begin : monitor
        frame_t want;
        if (!aresetn) begin
            show_number  = 1'b1;
            blink_on     = 1'b0;
            fixed_dot    = 1'b0;
            running_dot  = 1'b0;
            text_bytes   = '0;
            tick_count   = '0;
            blink_phase  = 1'b0;
            dot_position = '0;
            mismatches   = 0;
            frames_due.delete();
        end else begin
            // Register writes; indexes past the last register are ignored.
            if (cfg_we) begin
                case (cfg_index)
                    REG_NUMBER_MODE:   show_number = cfg_wdata[0];
                    REG_BLINK_ENABLE:  blink_on    = cfg_wdata[0];
                    REG_FIXED_DOT:     fixed_dot   = cfg_wdata[0];
                    REG_RUNNING_DOT:   running_dot = cfg_wdata[0];
                    REG_TEXT_SEGMENTS: text_bytes  = cfg_wdata;
                    default: ;
                endcase
            end

            if (s_valid && s_ready) begin
                refresh_digits(s_value);
            end

            // Compare each output beat with the oldest predicted frame.
            if (m_valid && m_ready) begin
                if (frames_due.size() == 0) begin
                    $display("%0t: unexpected frame, expected none, got grid %h seg %h last %b",
                             $time, m_grid_command, m_segments, m_last);
                    mismatches++;
                end else begin
                    want = frames_due.pop_front();
                    if (m_grid_command !== want.grid) begin
                        $display("%0t: grid_command expected %h, got %h",
                                 $time, want.grid, m_grid_command);
                        mismatches++;
                    end
                    if (m_segments !== want.seg) begin
                        $display("%0t: segments expected %h, got %h",
                                 $time, want.seg, m_segments);
                        mismatches++;
                    end
                    if (m_last !== want.last) begin
                        $display("%0t: last expected %b, got %b", $time, want.last, m_last);
                        mismatches++;
                    end
                end
            end
        end
        frames_pending = frames_due.size();
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;

    import ssre_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_ITEMS    = 100;
    localparam int RX_HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES    = 10;
    localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX = REG_TEXT_SEGMENTS + 3'd1;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic signed [VALUE_W-1:0] s_value;
    logic                      m_valid;
    logic                      m_ready;
    logic [GRID_W-1:0]         m_grid_command;
    logic [SEG_W-1:0]          m_segments;
    logic                      m_last;
    logic                      cfg_we;
    logic [CFG_INDEX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_wdata;

    int mismatches;
    int frames_pending;
    int cycle_count = 0;

    // Knobs shared between the sender and the receiver.
    logic tx_gaps     = 1'b0;
    logic rx_stalls   = 1'b0;
    logic rx_hold_req = 1'b0;

    seven_segment_refresh_engine_unit uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_grid_command (m_grid_command),
        .m_segments     (m_segments),
        .m_last         (m_last),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    ssre_frame_checker frame_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_grid_command (m_grid_command),
        .m_segments     (m_segments),
        .m_last         (m_last),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatches     (mismatches),
        .frames_pending (frames_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // Offer one input beat and return at the edge that accepts it.
    task automatic push_value(input logic signed [VALUE_W-1:0] v);
        s_valid <= 1'b1;
        s_value <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stop sending and wait until every predicted frame has come out.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (frames_pending != 0) @(posedge aclk);
    endtask

    // Write all registers back to back, then poke an unused index.
    task automatic apply_config(input logic num, input logic blink, input logic fixed,
                                input logic running, input logic [CFG_DATA_W-1:0] text);
        cfg_we    <= 1'b1;
        cfg_index <= REG_NUMBER_MODE;
        cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, num};
        @(posedge aclk);
        cfg_index <= REG_BLINK_ENABLE;
        cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, blink};
        @(posedge aclk);
        cfg_index <= REG_FIXED_DOT;
        cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, fixed};
        @(posedge aclk);
        cfg_index <= REG_RUNNING_DOT;
        cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, running};
        @(posedge aclk);
        cfg_index <= REG_TEXT_SEGMENTS;
        cfg_wdata <= text;
        @(posedge aclk);
        cfg_index <= SPARE_INDEX + CFG_INDEX_W'($urandom_range(0, 2));
        cfg_wdata <= CFG_DATA_W'($urandom);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Mostly in-range numbers, with out-of-range codes and extremes mixed in.
    function automatic logic signed [VALUE_W-1:0] random_value();
        int r;
        case ($urandom_range(0, 7))
            0: r = $urandom;
            1: begin
                case ($urandom_range(0, 4))
                    0: r = 999;
                    1: r = -999;
                    2: r = 1023;
                    3: r = -1024;
                    default: r = 0;
                endcase
            end
            default: r = $urandom_range(0, 1998) - 999;
        endcase
        return VALUE_W'(r);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_text();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    // Receiver: runs of ready and stalls, plus a long hold-off on request.
    initial begin
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            if (rx_hold_req) begin
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                rx_hold_req = 1'b0;
            end else if (rx_stalls && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        int sent;
        int phase;
        int count;
        int burst_left;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_value   = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_NUMBER_MODE;
        cfg_wdata = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset configuration: number mode, no blanking, no dots.
        push_value(11'sd0);
        push_value(11'sd1);
        push_value(11'sd9);
        push_value(11'sd10);
        push_value(11'sd99);
        push_value(11'sd100);
        push_value(11'sd999);
        push_value(-11'sd1);
        push_value(-11'sd9);
        push_value(-11'sd999);
        // Out-of-range magnitudes still show their low digits.
        push_value(11'sd1000);
        push_value(11'sd1023);
        push_value(-11'sd1000);
        push_value(-11'sd1024);

        // Text mode with all segments lit, blanking and the running dot.
        wait_idle();
        apply_config(1'b0, 1'b1, 1'b0, 1'b1, '1);
        rx_stalls = 1'b1;
        repeat (6) push_value(random_value());

        // Fixed dot overrides the running dot, also on a blanked display.
        wait_idle();
        apply_config(1'b1, 1'b1, 1'b1, 1'b1, '0);
        push_value(11'sd555);
        push_value(-11'sd45);
        push_value(11'sd888);
        push_value(11'sd7);
        push_value(-11'sd1024);

        // Random phases, each with its own settings and traffic shape.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_idle();
            apply_config(1'($urandom), 1'($urandom), $urandom_range(0, 2) == 0,
                         1'($urandom), random_text());
            tx_gaps   = (phase % 4 != 1);
            rx_stalls = (phase % 4 != 1);
            if (phase == 2) begin
                rx_hold_req = 1'b1;
            end
            count      = $urandom_range(8, 24);
            burst_left = $urandom_range(1, 8);
            for (int n = 0; n < count; n++) begin
                push_value(random_value());
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 8);
                    if (tx_gaps) begin
                        s_valid <= 1'b0;
                        repeat ($urandom_range(1, 6)) @(posedge aclk);
                    end
                end
            end
            sent += count;
            phase++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && frames_pending == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
